### src/prm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

  localparam int PEN_W       = 14;
  localparam int PRIO_W      = 3;
  localparam int PRIO_LSB    = 11;
  localparam int PRIO_ADDR_W = 15;
  localparam int CODE_W      = 3;
  localparam int LAYER_W     = 3;
  localparam int NUM_LANES   = 5;

  localparam logic [PEN_W-1:0] TRANSPARENT_PEN = 14'h003f;

  // layer ids: tile layers 0..3, sprites last
  localparam logic [LAYER_W-1:0] LAYER_TILE0  = 3'd0;
  localparam logic [LAYER_W-1:0] LAYER_TILE1  = 3'd1;
  localparam logic [LAYER_W-1:0] LAYER_TILE2  = 3'd2;
  localparam logic [LAYER_W-1:0] LAYER_TILE3  = 3'd3;
  localparam logic [LAYER_W-1:0] LAYER_SPRITE = 3'd4;

  // priority codes held in the ram
  localparam logic [CODE_W-1:0] CODE_SPRITE = 3'd3;
  localparam logic [CODE_W-1:0] CODE_TILE3  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_TILE1  = 3'd6;
  localparam logic [CODE_W-1:0] CODE_TILE2  = 3'd7;

  typedef logic [PEN_W-1:0] pen_t;

  typedef struct packed {
    logic              transp;
    logic [PRIO_W-1:0] prio;
  } lane_info_t;

  // unused codes fall back to layer 0
  function automatic logic [LAYER_W-1:0] code_to_layer(input logic [CODE_W-1:0] code);
    logic [LAYER_W-1:0] layer;
    case (code)
      CODE_SPRITE: layer = LAYER_SPRITE;
      CODE_TILE3:  layer = LAYER_TILE3;
      CODE_TILE1:  layer = LAYER_TILE1;
      CODE_TILE2:  layer = LAYER_TILE2;
      default:     layer = LAYER_TILE0;
    endcase
    return layer;
  endfunction

endpackage

`default_nettype wire

### src/prm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module prm_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32768,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/prm_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module prm_lane
  import prm_pkg::*;
(
  input  wire pen_t       pen,
  output lane_info_t      info
);

  always_comb begin
    info.transp = (pen == TRANSPARENT_PEN);
    info.prio   = pen[PRIO_LSB +: PRIO_W];
  end

endmodule

`default_nettype wire

### src/prm_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module prm_merge
  import prm_pkg::*;
(
  input  wire pen_t               pens [NUM_LANES],
  input  wire logic [CODE_W-1:0]  code,
  output pen_t                    pixel_pen,
  output logic      [LAYER_W-1:0] winning_layer
);

  always_comb begin
    winning_layer = code_to_layer(code);
    case (winning_layer)
      LAYER_TILE1:  pixel_pen = pens[1];
      LAYER_TILE2:  pixel_pen = pens[2];
      LAYER_TILE3:  pixel_pen = pens[3];
      LAYER_SPRITE: pixel_pen = pens[4];
      default:      pixel_pen = pens[0];
    endcase
  end

endmodule

`default_nettype wire

### src/priority_ram_layer_mixer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// out_valid rises once a mix beat has passed the ram read and then the output register
// throughput: one beat per cycle while the output is not stalled, set by the single read port of the priority ram
// write beats give no result; a mix may follow at once
// reset (rst_n low, synchronous) empties the pipeline; the priority ram is not cleared

module priority_ram_layer_mixer_unit
  import prm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_command,
  input  wire logic [PEN_W-1:0]       in_pen_layer_zero,
  input  wire logic [PEN_W-1:0]       in_pen_layer_one,
  input  wire logic [PEN_W-1:0]       in_pen_layer_two,
  input  wire logic [PEN_W-1:0]       in_pen_layer_three,
  input  wire logic [PEN_W-1:0]       in_pen_sprite,
  input  wire logic [PRIO_ADDR_W-1:0] in_write_address,
  input  wire logic [CODE_W-1:0]      in_write_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [PEN_W-1:0]       out_pixel_pen,
  output logic      [LAYER_W-1:0]     out_winning_layer
);

  // input pens as lanes: 0..3 tile layers, 4 sprites
  pen_t       in_pens [NUM_LANES];
  lane_info_t info    [NUM_LANES];

  assign in_pens[0] = in_pen_layer_zero;
  assign in_pens[1] = in_pen_layer_one;
  assign in_pens[2] = in_pen_layer_two;
  assign in_pens[3] = in_pen_layer_three;
  assign in_pens[4] = in_pen_sprite;

  // one lane per pen: transparency test and priority field
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    prm_lane u_lane (
      .pen  (in_pens[g]),
      .info (info[g])
    );
  end

  // priority ram address from the lane results
  logic [PRIO_ADDR_W-1:0] rd_addr;
  assign rd_addr = {info[3].prio[0], info[0].prio, info[4].prio, info[1].prio,
                    info[3].transp, info[4].transp, info[2].transp,
                    info[1].transp, info[0].transp};

  // handshake and pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic in_fire;
  logic mix_fire;
  logic wr_fire;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign mix_fire = in_fire && !in_command;
  assign wr_fire  = in_fire && in_command;

  // priority ram: writes from write beats, reads for mix beats
  logic [CODE_W-1:0] code;

  prm_ram #(
    .WIDTH (CODE_W),
    .DEPTH (1 << PRIO_ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_fire),
    .wr_addr (in_write_address),
    .wr_data (in_write_value),
    .rd_en   (mix_fire),
    .rd_addr (rd_addr),
    .rd_data (code)
  );

  // stage 1: pens wait beside the ram read
  pen_t s1_pens_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (mix_fire) begin
      s1_pens_r <= in_pens;
    end
  end

  // merge: code to layer, pick that lane's pen
  pen_t              mix_pen;
  logic [LAYER_W-1:0] mix_layer;

  prm_merge u_merge (
    .pens          (s1_pens_r),
    .code          (code),
    .pixel_pen     (mix_pen),
    .winning_layer (mix_layer)
  );

  // output register
  pen_t               out_pen_r;
  logic [LAYER_W-1:0] out_layer_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = !in_command;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_pen_r   <= mix_pen;
      out_layer_r <= mix_layer;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_pen     = out_pen_r;
  assign out_winning_layer = out_layer_r;

  // input only stalls when both stages hold a beat
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in pipeline");

  // a write beat never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    wr_fire |=> !s1_valid_r)
    else $error("write beat entered mix pipeline");

  // a stalled stage 1 beat is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("stage 1 beat lost under stall");

  // the winning layer is a real layer
  a_layer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_layer_r <= LAYER_SPRITE))
    else $error("winning layer out of range");

endmodule

`default_nettype wire

### tb/mix_tb_pkg.sv
`timescale 1ns / 1ps

package mix_tb_pkg;
  import prm_pkg::*;

  localparam logic CMD_MIX   = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // the five pens of one pixel, sprite lane on top
  typedef struct packed {
    pen_t sprite;
    pen_t tile3;
    pen_t tile2;
    pen_t tile1;
    pen_t tile0;
  } pen_set_t;

  typedef struct packed {
    pen_t               pen;
    logic [LAYER_W-1:0] layer;
  } pixel_t;

  // priority ram entry that a pixel looks up
  function automatic logic [PRIO_ADDR_W-1:0] prio_index(input pen_set_t p);
    logic [PRIO_ADDR_W-1:0] idx;
    idx        = '0;
    idx[0]     = (p.tile0 == TRANSPARENT_PEN);
    idx[1]     = (p.tile1 == TRANSPARENT_PEN);
    idx[2]     = (p.tile2 == TRANSPARENT_PEN);
    idx[3]     = (p.sprite == TRANSPARENT_PEN);
    idx[4]     = (p.tile3 == TRANSPARENT_PEN);
    idx[7:5]   = p.tile1[PRIO_LSB +: PRIO_W];
    idx[10:8]  = p.sprite[PRIO_LSB +: PRIO_W];
    idx[13:11] = p.tile0[PRIO_LSB +: PRIO_W];
    idx[14]    = p.tile3[PRIO_LSB];
    return idx;
  endfunction

endpackage

### tb/mix_checker.sv
`timescale 1ns / 1ps

module mix_checker
  import prm_pkg::*;
  import mix_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_command,
  input  logic [PEN_W-1:0]       in_pen_layer_zero,
  input  logic [PEN_W-1:0]       in_pen_layer_one,
  input  logic [PEN_W-1:0]       in_pen_layer_two,
  input  logic [PEN_W-1:0]       in_pen_layer_three,
  input  logic [PEN_W-1:0]       in_pen_sprite,
  input  logic [PRIO_ADDR_W-1:0] in_write_address,
  input  logic [CODE_W-1:0]      in_write_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [PEN_W-1:0]       out_pixel_pen,
  input  logic [LAYER_W-1:0]     out_winning_layer,
  output int                     fail_count,
  output int                     pending_pixels
);

  // layer picked by each stored code, indexed by code
  localparam logic [LAYER_W-1:0] LAYER_OF_CODE [1 << CODE_W] = '{
    LAYER_TILE0, LAYER_TILE0, LAYER_TILE0, LAYER_SPRITE,
    LAYER_TILE3, LAYER_TILE0, LAYER_TILE1, LAYER_TILE2
  };

  bit [CODE_W-1:0] code_mirror [0:(1 << PRIO_ADDR_W)-1];
  pixel_t          expected_pixels [$];
  pixel_t          want;

  function automatic pixel_t mix_pixel(input pen_set_t pens);
    pixel_t px;
    px.layer = LAYER_OF_CODE[code_mirror[prio_index(pens)]];
    case (px.layer)
      LAYER_TILE1:  px.pen = pens.tile1;
      LAYER_TILE2:  px.pen = pens.tile2;
      LAYER_TILE3:  px.pen = pens.tile3;
      LAYER_SPRITE: px.pen = pens.sprite;
      default:      px.pen = pens.tile0;
    endcase
    return px;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_command == CMD_WRITE) begin
          code_mirror[in_write_address] = in_write_value;
        end else begin
          expected_pixels.push_back(mix_pixel('{tile0: in_pen_layer_zero,
                                                 tile1: in_pen_layer_one,
                                                 tile2: in_pen_layer_two,
                                                 tile3: in_pen_layer_three,
                                                 sprite: in_pen_sprite}));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected beat: pixel_pen %h winning_layer %0d",
                 out_pixel_pen, out_winning_layer);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_pen !== want.pen) begin
            $error("pixel_pen: expected %h, got %h", want.pen, out_pixel_pen);
            fail_count++;
          end
          if (out_winning_layer !== want.layer) begin
            $error("winning_layer: expected %0d, got %0d", want.layer, out_winning_layer);
            fail_count++;
          end
        end
      end
    end
    pending_pixels = expected_pixels.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import prm_pkg::*;
  import mix_tb_pkg::*;

  localparam int RANDOM_BEATS = 1850;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  logic                   clk                = 1'b0;
  logic                   rst_n              = 1'b0;
  logic                   in_valid           = 1'b0;
  logic                   in_ready;
  logic                   in_command         = CMD_MIX;
  pen_t                   in_pen_layer_zero  = '0;
  pen_t                   in_pen_layer_one   = '0;
  pen_t                   in_pen_layer_two   = '0;
  pen_t                   in_pen_layer_three = '0;
  pen_t                   in_pen_sprite      = '0;
  logic [PRIO_ADDR_W-1:0] in_write_address   = '0;
  logic [CODE_W-1:0]      in_write_value     = '0;
  logic                   out_valid;
  logic                   out_ready          = 1'b0;
  pen_t                   out_pixel_pen;
  logic [LAYER_W-1:0]     out_winning_layer;

  int fail_count;
  int pending_pixels;
  int cycle_count = 0;
  int beats_sent  = 0;

  // idle knobs for both sides, and the long output hold-off
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left    = 0;

  // entries loaded so far: a pixel is only sent once its entry holds a code
  bit code_written [0:(1 << PRIO_ADDR_W)-1];

  priority_ram_layer_mixer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_pen_layer_zero  (in_pen_layer_zero),
    .in_pen_layer_one   (in_pen_layer_one),
    .in_pen_layer_two   (in_pen_layer_two),
    .in_pen_layer_three (in_pen_layer_three),
    .in_pen_sprite      (in_pen_sprite),
    .in_write_address   (in_write_address),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_pen      (out_pixel_pen),
    .out_winning_layer  (out_winning_layer)
  );

  mix_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_pen_layer_zero  (in_pen_layer_zero),
    .in_pen_layer_one   (in_pen_layer_one),
    .in_pen_layer_two   (in_pen_layer_two),
    .in_pen_layer_three (in_pen_layer_three),
    .in_pen_sprite      (in_pen_sprite),
    .in_write_address   (in_write_address),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_pen      (out_pixel_pen),
    .out_winning_layer  (out_winning_layer),
    .fail_count         (fail_count),
    .pending_pixels     (pending_pixels)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("priority_ram_layer_mixer_unit: mismatch");
      $finish;
    end
  end

  // output side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(sink_idle_on && $urandom_range(99) < 34);
      end
    end
  end

  // mostly random pens, some clear; some carry the clear colour under a priority
  function automatic pen_t rand_pen();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return TRANSPARENT_PEN;
    if (roll < 40) return {PRIO_W'($urandom), TRANSPARENT_PEN[PRIO_LSB-1:0]};
    return pen_t'($urandom);
  endfunction

  function automatic pen_set_t rand_pens();
    pen_set_t p;
    p.tile0  = rand_pen();
    p.tile1  = rand_pen();
    p.tile2  = rand_pen();
    p.tile3  = rand_pen();
    p.sprite = rand_pen();
    return p;
  endfunction

  // one beat on the input channel; valid may drop for a random gap first,
  // then stays up with a steady payload until accepted
  task automatic send_beat(input logic cmd, input pen_set_t pens,
                           input logic [PRIO_ADDR_W-1:0] addr,
                           input logic [CODE_W-1:0] code);
    if (src_idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_pen_layer_zero  <= pens.tile0;
    in_pen_layer_one   <= pens.tile1;
    in_pen_layer_two   <= pens.tile2;
    in_pen_layer_three <= pens.tile3;
    in_pen_sprite      <= pens.sprite;
    in_write_address   <= addr;
    in_write_value     <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // write beat: pen lanes carry junk, they must be ignored
  task automatic put_code(input logic [PRIO_ADDR_W-1:0] addr, input logic [CODE_W-1:0] code);
    send_beat(CMD_WRITE, rand_pens(), addr, code);
    code_written[addr] = 1'b1;
  endtask

  // mix beat: write lanes carry junk, they must be ignored
  task automatic put_pixel(input pen_set_t pens);
    send_beat(CMD_MIX, pens, PRIO_ADDR_W'($urandom), CODE_W'($urandom));
  endtask

  // mix a pixel, loading its entry with a random code first if still empty
  task automatic show_pixel(input pen_set_t pens);
    logic [PRIO_ADDR_W-1:0] idx;
    idx = prio_index(pens);
    if (!code_written[idx]) put_code(idx, CODE_W'($urandom));
    put_pixel(pens);
  endtask

  // load a given code for these pens, then mix them right behind the write
  task automatic write_then_show(input pen_set_t pens, input logic [CODE_W-1:0] code);
    put_code(prio_index(pens), code);
    put_pixel(pens);
  endtask

  initial begin
    pen_set_t opaque;
    pen_set_t last_pens;
    int       start;
    int       roll;
    bit       hold_done;

    // five opaque pens, each with its own priority and colour
    opaque.tile0  = 14'h2955;
    opaque.tile1  = 14'h12aa;
    opaque.tile2  = 14'h38f0;
    opaque.tile3  = 14'h0f0f;
    opaque.sprite = 14'h33c3;
    hold_done     = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every code, including the unused ones that fall back to layer 0
    for (int c = 0; c < (1 << CODE_W); c++) write_then_show(opaque, CODE_W'(c));
    // all lanes clear, sprite wins
    write_then_show('{default: TRANSPARENT_PEN}, CODE_SPRITE);
    // pen extremes
    write_then_show('0, CODE_TILE2);
    write_then_show('1, CODE_TILE3);
    // top entry of the ram, not reachable by any pixel
    put_code('1, CODE_TILE1);
    // rewrite the entry of the all-ones pens and read it back at once
    write_then_show('1, CODE_TILE1);

    // random part
    last_pens = opaque;
    start     = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      // a long stretch with no idling on either side
      src_idle_on  = !((beats_sent - start) >= 500 && (beats_sent - start) < 1000);
      sink_idle_on = src_idle_on;
      // one long output hold-off while the input keeps offering
      if (!hold_done && (beats_sent - start) >= 1300) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 60) begin
        last_pens = rand_pens();
        show_pixel(last_pens);
      end else if (roll < 72) begin
        // same pixel again, entry already loaded
        show_pixel(last_pens);
      end else if (roll < 84) begin
        // change the code under a pixel just seen, then read it
        write_then_show(last_pens, CODE_W'($urandom));
      end else begin
        put_code(PRIO_ADDR_W'($urandom), CODE_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    // let the pipeline drain, then keep watching for stray beats
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("priority_ram_layer_mixer_unit: match");
    end else begin
      $display("priority_ram_layer_mixer_unit: mismatch");
    end
    $finish;
  end

endmodule
